// ----- hw/rtl/pbsc_pkg.sv -----
// ----------------------------------------------------------------------------
// pbsc_pkg
// Shared types and codes for the plane / box / sphere classifier: request and
// response payloads, pipeline stage records, opcodes, region codes and
// register indexes.
// ----------------------------------------------------------------------------
package pbsc_pkg;

   localparam logic [2:0] OP_BOX    = 3'd0;
   localparam logic [2:0] OP_SPHERE = 3'd1;
   localparam logic [2:0] OP_POINT  = 3'd2;
   localparam logic [2:0] OP_NDOT   = 3'd3;
   localparam logic [2:0] OP_HDOT   = 3'd4;

   localparam logic [1:0] REGION_FRONT = 2'd0;
   localparam logic [1:0] REGION_BACK  = 2'd1;
   localparam logic [1:0] REGION_CROSS = 2'd2;
   localparam logic [1:0] REGION_NONE  = 2'd3;

   localparam logic [1:0] CSR_NORMAL_X = 2'd0;
   localparam logic [1:0] CSR_NORMAL_Y = 2'd1;
   localparam logic [1:0] CSR_NORMAL_Z = 2'd2;
   localparam logic [1:0] CSR_OFFSET   = 2'd3;

   typedef struct packed {
      logic        [2:0]  opcode;
      logic signed [31:0] a_x;
      logic signed [31:0] a_y;
      logic signed [31:0] a_z;
      logic signed [31:0] b_x;
      logic signed [31:0] b_y;
      logic signed [31:0] b_z;
      logic signed [31:0] extra;
   } req_type;

   typedef struct packed {
      logic signed [47:0] signed_value;
      logic        [1:0]  region;
   } rsp_type;

   typedef struct packed {
      logic signed [17:0] normal_x;
      logic signed [17:0] normal_y;
      logic signed [17:0] normal_z;
      logic signed [31:0] offset;
   } plane_type;

   typedef struct packed {
      logic               valid;
      logic        [2:0]  opcode;
      logic signed [31:0] near_x;
      logic signed [31:0] near_y;
      logic signed [31:0] near_z;
      logic signed [31:0] far_x;
      logic signed [31:0] far_y;
      logic signed [31:0] far_z;
      logic signed [31:0] extra;
   } stg1_type;

   typedef struct packed {
      logic               valid;
      logic        [2:0]  opcode;
      logic signed [49:0] pn_x;
      logic signed [49:0] pn_y;
      logic signed [49:0] pn_z;
      logic signed [49:0] pf_x;
      logic signed [49:0] pf_y;
      logic signed [49:0] pf_z;
      logic signed [63:0] off_ext;
      logic signed [31:0] extra;
   } stg2_type;

   typedef struct packed {
      logic               valid;
      logic        [2:0]  opcode;
      logic signed [63:0] near_sum;
      logic signed [63:0] far_sum;
      logic signed [47:0] radius;
   } stg3_type;

endpackage

// ----- hw/rtl/pbsc_mult.sv -----
// ----------------------------------------------------------------------------
// pbsc_mult
// Product stage: normal components times near and far corner coordinates,
// and the plane offset times the homogeneous w term.
// ----------------------------------------------------------------------------
module pbsc_mult (
   input  logic                clock,
   input  logic                reset,
   input  pbsc_pkg::plane_type plane,
   input  pbsc_pkg::stg1_type  stg1,
   output pbsc_pkg::stg2_type  stg2
);
   import pbsc_pkg::*;

   stg2_type stg2_ff;
   stg2_type stg2_in;

   always_comb begin
      stg2_in.valid   = stg1.valid;
      stg2_in.opcode  = stg1.opcode;
      stg2_in.pn_x    = 50'(plane.normal_x) * 50'(stg1.near_x);
      stg2_in.pn_y    = 50'(plane.normal_y) * 50'(stg1.near_y);
      stg2_in.pn_z    = 50'(plane.normal_z) * 50'(stg1.near_z);
      stg2_in.pf_x    = 50'(plane.normal_x) * 50'(stg1.far_x);
      stg2_in.pf_y    = 50'(plane.normal_y) * 50'(stg1.far_y);
      stg2_in.pf_z    = 50'(plane.normal_z) * 50'(stg1.far_z);
      stg2_in.off_ext = 64'(plane.offset) * 64'(stg1.extra);
      stg2_in.extra   = stg1.extra;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg2_ff <= '0;
      end else begin
         stg2_ff <= stg2_in;
      end
   end

   assign stg2 = stg2_ff;

endmodule

// ----- hw/rtl/pbsc_sum.sv -----
// ----------------------------------------------------------------------------
// pbsc_sum
// Sum stage: exact near and far corner distances at 2^-32 scale, with the
// offset term chosen by opcode, and the radius scaled for the sphere test.
// ----------------------------------------------------------------------------
module pbsc_sum (
   input  logic                clock,
   input  logic                reset,
   input  pbsc_pkg::plane_type plane,
   input  pbsc_pkg::stg2_type  stg2,
   output pbsc_pkg::stg3_type  stg3
);
   import pbsc_pkg::*;

   stg3_type           stg3_ff;
   stg3_type           stg3_in;
   logic signed [63:0] off_wide;
   logic signed [63:0] near_term;
   logic signed [63:0] near_dot;
   logic signed [63:0] far_dot;

   always_comb begin
      off_wide = {{16{plane.offset[31]}}, plane.offset, 16'b0};
      near_dot = 64'(stg2.pn_x) + 64'(stg2.pn_y) + 64'(stg2.pn_z);
      far_dot  = 64'(stg2.pf_x) + 64'(stg2.pf_y) + 64'(stg2.pf_z);
      case (stg2.opcode)
         OP_HDOT: near_term = stg2.off_ext;
         OP_NDOT: near_term = '0;
         default: near_term = off_wide;
      endcase
      stg3_in.valid    = stg2.valid;
      stg3_in.opcode   = stg2.opcode;
      stg3_in.near_sum = near_dot + near_term;
      stg3_in.far_sum  = far_dot + off_wide;
      stg3_in.radius   = {stg2.extra, 16'b0};
      if (stg2.opcode > OP_HDOT) begin
         stg3_in.near_sum = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg3_ff <= '0;
      end else begin
         stg3_ff <= stg3_in;
      end
   end

   assign stg3 = stg3_ff;

endmodule

// ----- hw/rtl/pbsc_class.sv -----
// ----------------------------------------------------------------------------
// pbsc_class
// Classify stage: region decision by opcode, floor to Q16.16 and saturate
// the value to 48 bits; drives the response register and its strobe.
// ----------------------------------------------------------------------------
module pbsc_class (
   input  logic               clock,
   input  logic               reset,
   input  pbsc_pkg::stg3_type stg3,
   output logic               rsp_valid,
   output pbsc_pkg::rsp_type  rsp_data
);
   import pbsc_pkg::*;

   logic               valid_ff;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;
   logic signed [63:0] shifted;
   logic signed [63:0] rad_wide;

   always_comb begin
      shifted  = stg3.near_sum >>> 16;
      rad_wide = 64'(stg3.radius);
      if (shifted[63:47] == {17{shifted[63]}}) begin
         rsp_in.signed_value = shifted[47:0];
      end else if (shifted[63]) begin
         rsp_in.signed_value = {1'b1, 47'b0};
      end else begin
         rsp_in.signed_value = {1'b0, {47{1'b1}}};
      end
      case (stg3.opcode)
         OP_BOX: begin
            if (stg3.near_sum > 64'sd0) begin
               rsp_in.region = REGION_FRONT;
            end else if (stg3.far_sum < 64'sd0) begin
               rsp_in.region = REGION_BACK;
            end else begin
               rsp_in.region = REGION_CROSS;
            end
         end
         OP_SPHERE: begin
            if (stg3.near_sum > rad_wide) begin
               rsp_in.region = REGION_FRONT;
            end else if (stg3.near_sum < -rad_wide) begin
               rsp_in.region = REGION_BACK;
            end else begin
               rsp_in.region = REGION_CROSS;
            end
         end
         default: rsp_in.region = REGION_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= stg3.valid;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- hw/rtl/plane_box_sphere_classify.sv -----
// ----------------------------------------------------------------------------
// plane_box_sphere_classify
// Throughput: one request per cycle while busy is low; four register stages
// (select, multiply, sum, classify), each with its own valid bit.
// Reset clears the plane registers and all valid bits; busy is set by reset
// and is cleared on a clock edge without reset, after which it stays low.
// ----------------------------------------------------------------------------
module plane_box_sphere_classify (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  pbsc_pkg::req_type req_data,
   output logic              rsp_valid,
   output pbsc_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata
);
   import pbsc_pkg::*;

   logic      busy_ff;
   plane_type plane_ff;
   stg1_type  stg1_ff;
   stg1_type  stg1_in;
   stg2_type  stg2;
   stg3_type  stg3;
   logic      take_box;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         plane_ff <= '0;
      end else begin
         busy_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_NORMAL_X: plane_ff.normal_x <= csr_wdata[17:0];
               CSR_NORMAL_Y: plane_ff.normal_y <= csr_wdata[17:0];
               CSR_NORMAL_Z: plane_ff.normal_z <= csr_wdata[17:0];
               CSR_OFFSET:   plane_ff.offset   <= csr_wdata;
               default:      plane_ff          <= plane_ff;
            endcase
         end
      end
   end

   assign busy      = busy_ff;
   assign csr_ready = 1'b1;

   // box: near corner is the one lowest along the normal, far corner the highest; other opcodes use a as the near point
   always_comb begin
      take_box       = (req_data.opcode == OP_BOX);
      stg1_in.valid  = start && !busy_ff;
      stg1_in.opcode = req_data.opcode;
      stg1_in.extra  = req_data.extra;
      stg1_in.near_x = (take_box && plane_ff.normal_x[17]) ? req_data.b_x : req_data.a_x;
      stg1_in.near_y = (take_box && plane_ff.normal_y[17]) ? req_data.b_y : req_data.a_y;
      stg1_in.near_z = (take_box && plane_ff.normal_z[17]) ? req_data.b_z : req_data.a_z;
      stg1_in.far_x  = plane_ff.normal_x[17] ? req_data.a_x : req_data.b_x;
      stg1_in.far_y  = plane_ff.normal_y[17] ? req_data.a_y : req_data.b_y;
      stg1_in.far_z  = plane_ff.normal_z[17] ? req_data.a_z : req_data.b_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg1_ff <= '0;
      end else begin
         stg1_ff <= stg1_in;
      end
   end

   pbsc_mult u_mult (
      .clock (clock),
      .reset (reset),
      .plane (plane_ff),
      .stg1  (stg1_ff),
      .stg2  (stg2)
   );

   pbsc_sum u_sum (
      .clock (clock),
      .reset (reset),
      .plane (plane_ff),
      .stg2  (stg2),
      .stg3  (stg3)
   );

   pbsc_class u_class (
      .clock     (clock),
      .reset     (reset),
      .stg3      (stg3),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- hw/rtl/pbsc_checker.sv -----
// ----------------------------------------------------------------------------
// pbsc_checker
// Port-level checks on the classifier: fixed response latency, no response
// without a request, no region code for dot opcodes, busy after reset.
// ----------------------------------------------------------------------------
module pbsc_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input pbsc_pkg::req_type req_data,
   input logic              rsp_valid,
   input pbsc_pkg::rsp_type rsp_data
);
   import pbsc_pkg::*;

   logic accept;
   logic dot_op;

   assign accept = start && !busy;
   assign dot_op = (req_data.opcode == OP_POINT) || (req_data.opcode == OP_NDOT)
                   || (req_data.opcode == OP_HDOT);

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##4 rsp_valid)
      else $error("response missing four cycles after request");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 4))
      else $error("response without matching request");

   a_dot_region: assert property (@(posedge clock) disable iff (reset)
      (accept && dot_op) |-> ##4 (rsp_data.region == REGION_NONE))
      else $error("dot opcode returned a region");

   a_busy_reset: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> busy)
      else $error("busy low right after reset");

endmodule

bind plane_box_sphere_classify pbsc_checker u_pbsc_checker (.*);

// ----- test/plane_box_sphere_classify_checker.sv -----
// ----------------------------------------------------------------------------
// plane_box_sphere_classify_checker
// Watches the request, response and register channels of the plane / box /
// sphere classifier. Keeps its own copy of the plane, works out the answer to
// every accepted request at full precision, and compares each response in
// order against the oldest answer still waiting.
// ----------------------------------------------------------------------------
module plane_box_sphere_classify_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  pbsc_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  pbsc_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata,
   output int                failures,
   output int                outstanding
);
   import pbsc_pkg::*;

   localparam longint VALUE_HI = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint VALUE_LO = -VALUE_HI - 1;

   plane_type plane;
   rsp_type   pending_answers [$];

   initial begin
      failures    = 0;
      outstanding = 0;
   end

   function automatic longint plane_dot(plane_type pl, longint px, longint py, longint pz);
      return longint'(pl.normal_x) * px + longint'(pl.normal_y) * py
           + longint'(pl.normal_z) * pz;
   endfunction

   // floor from 2^-32 scale to Q16.16, then clamp to 48 bits
   function automatic logic signed [47:0] floor_clamp(longint exact);
      longint q;
      q = exact >>> 16;
      if (q > VALUE_HI) q = VALUE_HI;
      if (q < VALUE_LO) q = VALUE_LO;
      return q[47:0];
   endfunction

   function automatic rsp_type classify_query(req_type rq, plane_type pl);
      longint     offset_fine;
      longint     radius_fine;
      longint     near_sum;
      longint     far_sum;
      longint     exact;
      logic [1:0] zone;
      rsp_type    answer;
      offset_fine = longint'(pl.offset) * 65536;
      exact = 0;
      zone  = REGION_NONE;
      case (rq.opcode)
         OP_BOX: begin
            near_sum = plane_dot(pl, (pl.normal_x >= 0) ? rq.a_x : rq.b_x,
                                     (pl.normal_y >= 0) ? rq.a_y : rq.b_y,
                                     (pl.normal_z >= 0) ? rq.a_z : rq.b_z) + offset_fine;
            far_sum  = plane_dot(pl, (pl.normal_x >= 0) ? rq.b_x : rq.a_x,
                                     (pl.normal_y >= 0) ? rq.b_y : rq.a_y,
                                     (pl.normal_z >= 0) ? rq.b_z : rq.a_z) + offset_fine;
            exact = near_sum;
            if (near_sum > 0) zone = REGION_FRONT;
            else if (far_sum < 0) zone = REGION_BACK;
            else zone = REGION_CROSS;
         end
         OP_SPHERE: begin
            radius_fine = longint'(rq.extra) * 65536;
            exact = plane_dot(pl, rq.a_x, rq.a_y, rq.a_z) + offset_fine;
            if (exact > radius_fine) zone = REGION_FRONT;
            else if (exact < -radius_fine) zone = REGION_BACK;
            else zone = REGION_CROSS;
         end
         OP_POINT: exact = plane_dot(pl, rq.a_x, rq.a_y, rq.a_z) + offset_fine;
         OP_NDOT:  exact = plane_dot(pl, rq.a_x, rq.a_y, rq.a_z);
         OP_HDOT:  exact = plane_dot(pl, rq.a_x, rq.a_y, rq.a_z)
                         + longint'(pl.offset) * longint'(rq.extra);
         default:  exact = 0;
      endcase
      answer.signed_value = floor_clamp(exact);
      answer.region       = zone;
      return answer;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         plane = '0;
         pending_answers.delete();
      end else begin
         if (rsp_valid) begin
            if (pending_answers.size() == 0) begin
               $error("response with no request waiting: signed_value %0d, region %0d",
                      rsp_data.signed_value, rsp_data.region);
               failures++;
            end else begin
               want = pending_answers.pop_front();
               if (rsp_data.signed_value !== want.signed_value) begin
                  $error("signed_value: expected %0d, actual %0d",
                         want.signed_value, rsp_data.signed_value);
                  failures++;
               end
               if (rsp_data.region !== want.region) begin
                  $error("region: expected %0d, actual %0d", want.region, rsp_data.region);
                  failures++;
               end
            end
         end
         if (start && !busy) pending_answers.push_back(classify_query(req_data, plane));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_NORMAL_X: plane.normal_x = csr_wdata[17:0];
               CSR_NORMAL_Y: plane.normal_y = csr_wdata[17:0];
               CSR_NORMAL_Z: plane.normal_z = csr_wdata[17:0];
               CSR_OFFSET:   plane.offset   = csr_wdata;
               default: ;
            endcase
         end
      end
      outstanding <= pending_answers.size();
   end

endmodule

// ----- test/plane_box_sphere_classify_test.sv -----
// ----------------------------------------------------------------------------
// plane_box_sphere_classify_test
// Drives the plane / box / sphere classifier: a directed set of boundary,
// rounding and extreme queries, then random queries under a series of planes
// (zero, both extremes, mixed and random), with random gaps on the request
// side. The checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module plane_box_sphere_classify_test;
   import pbsc_pkg::*;

   localparam int RANDOM_ITEMS = 1850;
   localparam int PHASES       = 10;
   localparam int CALM_TAIL    = 200;

   logic        clock;
   logic        reset     = 1'b1;
   logic        start     = 1'b0;
   req_type     req_data  = '0;
   logic        csr_valid = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;
   logic        busy;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_ready;
   int          failures;
   int          outstanding;

   plane_box_sphere_classify i_dut (
      .clock, .reset, .start, .busy, .req_data, .rsp_valid, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata
   );

   plane_box_sphere_classify_checker i_checker (
      .clock, .reset, .start, .busy, .req_data, .rsp_valid, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata, .failures, .outstanding
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   task automatic load_plane(input logic [17:0] norm_x, input logic [17:0] norm_y,
                             input logic [17:0] norm_z, input logic [31:0] offset);
      logic [1:0]  index_list [4];
      logic [31:0] value_list [4];
      index_list = '{CSR_NORMAL_X, CSR_NORMAL_Y, CSR_NORMAL_Z, CSR_OFFSET};
      value_list = '{{{14{norm_x[17]}}, norm_x}, {{14{norm_y[17]}}, norm_y},
                     {{14{norm_z[17]}}, norm_z}, offset};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= index_list[i];
         csr_wdata <= value_list[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic send(input req_type item);
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
   endtask

   task automatic pause(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // hold off until every response is back
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   function automatic req_type make_req(input logic [2:0] op,
                                        input logic [31:0] ax, input logic [31:0] ay,
                                        input logic [31:0] az, input logic [31:0] bx,
                                        input logic [31:0] by, input logic [31:0] bz,
                                        input logic [31:0] ex);
      req_type item;
      item = '{op, ax, ay, az, bx, by, bz, ex};
      return item;
   endfunction

   function automatic logic [31:0] random_coord();
      int spread;
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         1, 2, 3: return $urandom();
         default: begin
            spread = $urandom_range(0, 32'h20_0000);
            return spread - 32'sh10_0000;
         end
      endcase
   endfunction

   function automatic logic [17:0] random_normal();
      int spread;
      case ($urandom_range(0, 5))
         0: begin
            case ($urandom_range(0, 2))
               0: return 18'h1FFFF;
               1: return 18'h20000;
               default: return 18'h00000;
            endcase
         end
         1, 2: return 18'($urandom());
         3: begin
            spread = $urandom_range(0, 32'h200);
            return 18'(spread - 32'sh100);
         end
         default: begin
            spread = $urandom_range(0, 32'h2_0000);
            return 18'(spread - 32'sh1_0000);
         end
      endcase
   endfunction

   function automatic req_type random_item();
      logic [2:0] op_list [5];
      req_type    item;
      int         pick;
      op_list = '{OP_BOX, OP_SPHERE, OP_POINT, OP_NDOT, OP_HDOT};
      pick = $urandom_range(0, 15);
      item.opcode = (pick < 15) ? op_list[pick % 5]
                                : 3'($urandom_range(int'(OP_HDOT) + 1, 7));
      item.a_x = random_coord();
      item.a_y = random_coord();
      item.a_z = random_coord();
      if ($urandom_range(0, 6) != 0) begin
         item.b_x = item.a_x + $urandom_range(0, 32'h4_0000);
         item.b_y = item.a_y + $urandom_range(0, 32'h4_0000);
         item.b_z = item.a_z + $urandom_range(0, 32'h4_0000);
      end else begin
         item.b_x = random_coord();
         item.b_y = random_coord();
         item.b_z = random_coord();
      end
      item.extra = ($urandom_range(0, 4) == 0) ? random_coord()
                                               : 32'($urandom_range(0, 32'h8_0000));
      return item;
   endfunction

   initial begin
      int sent;
      sent = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // plane x - y/2 - 1 = 0, with a zero z component
      load_plane(18'h10000, 18'h38000, 18'h00000, 32'hFFFF_0000);
      send(make_req(OP_BOX, 32'h1_0000, 0, 0, 32'h2_0000, 0, 0, 0));
      send(make_req(OP_BOX, 32'h3_0000, 0, 5, 32'h4_0000, 0, 9, 0));
      send(make_req(OP_BOX, -32'sh5_0000, 0, 0, -32'sh3_0000, 0, 0, 0));
      send(make_req(OP_BOX, 32'h4_0000, 32'h1_0000, 7, -32'sh4_0000, -32'sh1_0000, -7, 0));
      send(make_req(OP_BOX, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
      send(make_req(OP_BOX, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0));
      send(make_req(OP_SPHERE, 32'h3_0000, 0, 0, 0, 0, 0, 32'h2_0000));
      send(make_req(OP_SPHERE, -32'sh1_0000, 0, 0, 0, 0, 0, 32'h2_0000));
      send(make_req(OP_SPHERE, 32'h1_0000, 0, 0, 0, 0, 0, -32'sh1_0000));
      send(make_req(OP_SPHERE, 0, 0, 0, 0, 0, 0, 32'h8000_0000));
      send(make_req(OP_SPHERE, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 32'h7FFF_FFFF));
      send(make_req(OP_POINT, 1, 1, 0, 0, 0, 0, 0));
      send(make_req(OP_NDOT, 0, 1, 0, 0, 0, 0, 0));
      send(make_req(OP_NDOT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0));
      send(make_req(OP_HDOT, 3, 5, 0, 0, 0, 0, 32'h7FFF_FFFF));
      send(make_req(OP_HDOT, -32'sh2, 0, 0, 0, 0, 0, 32'h8000_0000));
      for (int op = int'(OP_HDOT) + 1; op < 8; op++)
         send(make_req(3'(op), '1, '1, '1, '1, '1, '1, '1));
      send(make_req(OP_POINT, 0, 0, 0, 0, 0, 0, 0));
      drain();

      load_plane(18'h20000, 18'h20000, 18'h20000, 32'h8000_0000);
      send(make_req(OP_HDOT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    0, 0, 0, 32'h8000_0000));
      send(make_req(OP_BOX, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
      send(make_req(OP_NDOT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0));
      send(make_req(OP_SPHERE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    0, 0, 0, 32'h7FFF_FFFF));
      drain();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: load_plane(18'h00000, 18'h00000, 18'h00000, 32'h0000_0000);
            1: load_plane(18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 32'h7FFF_FFFF);
            2: load_plane(18'h20000, 18'h20000, 18'h20000, 32'h8000_0000);
            3: load_plane(18'h1FFFF, 18'h20000, 18'h00000, 32'h8000_0000);
            default: load_plane(random_normal(), random_normal(), random_normal(),
                                random_coord());
         endcase
         for (int k = 0; k < RANDOM_ITEMS / PHASES; k++) begin
            send(random_item());
            sent++;
            if (sent < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 5) == 0)
               pause($urandom_range(1, 14));
         end
         drain();
      end

      repeat (8) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
